>>> sv/antialiased_line_rasterizer_defines.svh
// assertion helpers for the rasterizer module
`ifndef ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AALR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AALR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/aalr_pkg.sv
`timescale 1ns / 1ps

package aalr_pkg;

   // fixed payload width of the palette index
   localparam int COLOR_BITS = 4;

   // command codes of an input item
   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } command_type;

   // line classes, decided at load time
   typedef enum logic [2:0] {
      KIND_HORIZ  = 3'd0,
      KIND_VERT   = 3'd1,
      KIND_DIAG   = 3'd2,
      KIND_XMAJOR = 3'd3,
      KIND_YMAJOR = 3'd4
   } line_kind_type;

endpackage

>>> sv/aalr_if.sv
`timescale 1ns / 1ps

// command channel into the rasterizer
interface aalr_req_if #(
   parameter int COORD_BITS = 12
);
   import aalr_pkg::*;

   logic                    valid;
   logic                    ready;
   command_type             command;
   logic [COORD_BITS-1:0]   start_x;
   logic [COORD_BITS-1:0]   start_y;
   logic [COORD_BITS-1:0]   end_x;
   logic [COORD_BITS-1:0]   end_y;
   logic [COLOR_BITS-1:0]   color_index;

   modport source (
      output valid, command, start_x, start_y, end_x, end_y, color_index,
      input  ready
   );
   modport sink (
      input  valid, command, start_x, start_y, end_x, end_y, color_index,
      output ready
   );
endinterface

// pixel channel out of the rasterizer
interface aalr_rsp_if #(
   parameter int COORD_BITS  = 12,
   parameter int WEIGHT_BITS = 8
);
   import aalr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [COORD_BITS-1:0]   pixel_x;
   logic [COORD_BITS-1:0]   pixel_y;
   logic [COLOR_BITS-1:0]   pixel_color;
   logic [WEIGHT_BITS-1:0]  weight;
   logic                    last_of_run;
   logic                    line_done;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, weight, last_of_run, line_done,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, weight, last_of_run, line_done,
      output ready
   );
endinterface

>>> sv/aalr_divider.sv
`timescale 1ns / 1ps

// restoring divider: quotient = (numer << QUOT_BITS) / denom, numer < denom
// one quotient bit per cycle
module aalr_divider #(
   parameter int DIVIDEND_BITS = 12,
   parameter int QUOT_BITS     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] numer,
   input  logic [DIVIDEND_BITS-1:0] denom,
   output logic                     done,
   output logic [QUOT_BITS-1:0]     quotient
);
   localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

   logic                     active_ff;
   logic                     done_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic [DIVIDEND_BITS-1:0] rem_ff;
   logic [DIVIDEND_BITS-1:0] denom_ff;
   logic [QUOT_BITS-1:0]     quot_ff;

   logic [DIVIDEND_BITS:0]   shifted;
   logic                     qbit;
   logic [DIVIDEND_BITS-1:0] rem_in;

   // one trial subtraction
   always_comb begin
      shifted = {rem_ff, 1'b0};
      qbit    = (shifted >= {1'b0, denom_ff});
      rem_in  = qbit ? DIVIDEND_BITS'(shifted - {1'b0, denom_ff})
                     : DIVIDEND_BITS'(shifted);
   end

   // iteration control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         // done pulses with the last quotient bit
         done_ff <= !start && active_ff && (cnt_ff == CNT_BITS'(1));
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= CNT_BITS'(QUOT_BITS);
            rem_ff    <= numer;
            denom_ff  <= denom;
            quot_ff   <= '0;
         end else if (active_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[QUOT_BITS-2:0], qbit};
            cnt_ff  <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> sv/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps

// Antialiased line rasterizer (Wu). A load item takes two endpoints and a
// color, orders them so rows run upward and returns the exact first pixel;
// each step item then returns the next pixel, or for lines that are neither
// horizontal, vertical nor diagonal a weighted pair of neighboring pixels,
// with the endpoint returned exactly and flagged as the line's last pixel.
// Items are handled one at a time: the block takes an item, presents its one
// or two pixels from the next cycle on, and is ready again once the last
// pixel is taken, the output register has emptied and the sequencer has
// gone back to idle. A load of a general slope line also runs the shared
// restoring divider for the fractional error step, one quotient bit per
// cycle. Steps on an idle block are taken and return nothing. Coordinates
// wrap at COORD_BITS.
module antialiased_line_rasterizer #(
   parameter int COORD_BITS    = 12,
   parameter int FRACTION_BITS = 16,
   parameter int WEIGHT_BITS   = 8
) (
   input  logic       clock,
   input  logic       reset,
   aalr_req_if.sink   req_chan,
   aalr_rsp_if.source rsp_chan
);
   import aalr_pkg::*;

   `include "antialiased_line_rasterizer_defines.svh"

   localparam int STEP_BITS = COORD_BITS + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_OUT
   } state_type;

   state_type                state_ff;

   // line state
   logic [COORD_BITS-1:0]    cur_x_ff, cur_y_ff, final_x_ff, final_y_ff;
   logic                     step_left_ff;
   logic [STEP_BITS-1:0]     steps_ff;
   logic [FRACTION_BITS-1:0] error_acc_ff, error_step_ff;
   line_kind_type            kind_ff;
   logic [COLOR_BITS-1:0]    color_ff;
   logic                     line_busy_ff;

   // divider operands
   logic                     div_start_ff;
   logic [COORD_BITS-1:0]    div_num_ff, div_den_ff;
   logic                     div_done;
   logic [FRACTION_BITS-1:0] div_quot;

   // output register and second pixel of a pair
   logic                     rsp_valid_ff;
   logic [COORD_BITS-1:0]    rsp_x_ff, rsp_y_ff;
   logic [WEIGHT_BITS-1:0]   rsp_w_ff;
   logic                     rsp_last_ff, rsp_done_ff;
   logic                     pend_valid_ff;
   logic [COORD_BITS-1:0]    pend_x_ff, pend_y_ff;
   logic [WEIGHT_BITS-1:0]   pend_w_ff;

   logic                     req_take, rsp_take;

   // load decode
   logic [COORD_BITS-1:0]    ld_x0, ld_y0, ld_x1, ld_y1, ld_dx, ld_dy;
   logic                     ld_left;
   line_kind_type            ld_kind;
   logic [COORD_BITS-1:0]    ld_steps;
   logic                     ld_general;

   // step datapath
   logic [FRACTION_BITS:0]   acc_sum;
   logic                     carry;
   logic [FRACTION_BITS-1:0] acc_in;
   logic [WEIGHT_BITS-1:0]   st_w;
   logic [COORD_BITS-1:0]    x_adv, y_inc;
   logic [COORD_BITS-1:0]    st_x_in, st_y_in;
   logic [COORD_BITS-1:0]    st_px, st_py;
   logic                     st_final;
   logic                     st_pair;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   // load: order endpoints, deltas and line class
   always_comb begin
      if (req_chan.start_y > req_chan.end_y) begin
         ld_x0 = req_chan.end_x;
         ld_y0 = req_chan.end_y;
         ld_x1 = req_chan.start_x;
         ld_y1 = req_chan.start_y;
      end else begin
         ld_x0 = req_chan.start_x;
         ld_y0 = req_chan.start_y;
         ld_x1 = req_chan.end_x;
         ld_y1 = req_chan.end_y;
      end
      ld_left = (ld_x1 < ld_x0);
      ld_dx   = ld_left ? (ld_x0 - ld_x1) : (ld_x1 - ld_x0);
      ld_dy   = ld_y1 - ld_y0;
      if (ld_dy == '0) begin
         ld_kind  = KIND_HORIZ;
         ld_steps = ld_dx;
      end else if (ld_dx == '0) begin
         ld_kind  = KIND_VERT;
         ld_steps = ld_dy;
      end else if (ld_dx == ld_dy) begin
         ld_kind  = KIND_DIAG;
         ld_steps = ld_dy;
      end else if (ld_dx > ld_dy) begin
         ld_kind  = KIND_XMAJOR;
         ld_steps = ld_dx;
      end else begin
         ld_kind  = KIND_YMAJOR;
         ld_steps = ld_dy;
      end
      ld_general = (ld_kind == KIND_XMAJOR) || (ld_kind == KIND_YMAJOR);
   end

   // step: error accumulate, next position and neighbor pixel
   always_comb begin
      acc_sum  = {1'b0, error_acc_ff} + {1'b0, error_step_ff};
      carry    = acc_sum[FRACTION_BITS];
      acc_in   = acc_sum[FRACTION_BITS-1:0];
      st_w     = acc_in[FRACTION_BITS-1 -: WEIGHT_BITS];
      x_adv    = step_left_ff ? (cur_x_ff - COORD_BITS'(1)) : (cur_x_ff + COORD_BITS'(1));
      y_inc    = cur_y_ff + COORD_BITS'(1);
      st_final = (steps_ff <= STEP_BITS'(1));
      st_pair  = 1'b0;
      st_x_in  = cur_x_ff;
      st_y_in  = cur_y_ff;
      case (kind_ff)
         KIND_HORIZ: begin
            st_x_in = x_adv;
         end
         KIND_VERT: begin
            st_y_in = y_inc;
         end
         KIND_DIAG: begin
            st_x_in = x_adv;
            st_y_in = y_inc;
         end
         KIND_XMAJOR: begin
            st_pair = 1'b1;
            st_x_in = x_adv;
            st_y_in = carry ? y_inc : cur_y_ff;
         end
         KIND_YMAJOR: begin
            st_pair = 1'b1;
            st_x_in = carry ? x_adv : cur_x_ff;
            st_y_in = y_inc;
         end
         default: begin
            st_pair = 1'b0;
         end
      endcase
      // neighbor on the minor axis
      if (kind_ff == KIND_XMAJOR) begin
         st_px = st_x_in;
         st_py = st_y_in + COORD_BITS'(1);
      end else begin
         st_px = step_left_ff ? (st_x_in - COORD_BITS'(1)) : (st_x_in + COORD_BITS'(1));
         st_py = st_y_in;
      end
   end

   // sequencer, line state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         line_busy_ff  <= 1'b0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         final_x_ff    <= '0;
         final_y_ff    <= '0;
         step_left_ff  <= 1'b0;
         steps_ff      <= '0;
         error_acc_ff  <= '0;
         error_step_ff <= '0;
         kind_ff       <= KIND_HORIZ;
         color_ff      <= '0;
      end else begin
         // divider kicks off for a general line load
         div_start_ff <= req_take && (state_ff == S_IDLE) &&
                         (req_chan.command == CMD_LOAD) && ld_general;

         // hand over a taken pixel, or the waiting second one
         if (rsp_take) begin
            if (pend_valid_ff) begin
               rsp_x_ff      <= pend_x_ff;
               rsp_y_ff      <= pend_y_ff;
               rsp_w_ff      <= pend_w_ff;
               rsp_last_ff   <= 1'b1;
               rsp_done_ff   <= 1'b0;
               pend_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take && req_chan.command == CMD_LOAD) begin
                  cur_x_ff      <= ld_x0;
                  cur_y_ff      <= ld_y0;
                  final_x_ff    <= ld_x1;
                  final_y_ff    <= ld_y1;
                  step_left_ff  <= ld_left;
                  steps_ff      <= {1'b0, ld_steps};
                  error_acc_ff  <= '0;
                  error_step_ff <= '0;
                  kind_ff       <= ld_kind;
                  color_ff      <= req_chan.color_index;
                  line_busy_ff  <= (ld_steps != '0);
                  rsp_valid_ff  <= 1'b1;
                  rsp_x_ff      <= ld_x0;
                  rsp_y_ff      <= ld_y0;
                  rsp_w_ff      <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_done_ff   <= (ld_steps == '0);
                  if (ld_general) begin
                     div_num_ff   <= (ld_kind == KIND_XMAJOR) ? ld_dy : ld_dx;
                     div_den_ff   <= (ld_kind == KIND_XMAJOR) ? ld_dx : ld_dy;
                     state_ff     <= S_DIV;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else if (req_take && line_busy_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
                  if (st_final) begin
                     steps_ff     <= '0;
                     line_busy_ff <= 1'b0;
                     cur_x_ff     <= final_x_ff;
                     cur_y_ff     <= final_y_ff;
                     rsp_x_ff     <= final_x_ff;
                     rsp_y_ff     <= final_y_ff;
                     rsp_w_ff     <= '0;
                     rsp_last_ff  <= 1'b1;
                     rsp_done_ff  <= 1'b1;
                  end else begin
                     steps_ff    <= steps_ff - STEP_BITS'(1);
                     cur_x_ff    <= st_x_in;
                     cur_y_ff    <= st_y_in;
                     rsp_x_ff    <= st_x_in;
                     rsp_y_ff    <= st_y_in;
                     rsp_done_ff <= 1'b0;
                     if (st_pair) begin
                        error_acc_ff  <= acc_in;
                        rsp_w_ff      <= st_w;
                        rsp_last_ff   <= 1'b0;
                        pend_valid_ff <= 1'b1;
                        pend_x_ff     <= st_px;
                        pend_y_ff     <= st_py;
                        pend_w_ff     <= ~st_w;
                     end else begin
                        rsp_w_ff    <= '0;
                        rsp_last_ff <= 1'b1;
                     end
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  error_step_ff <= div_quot;
                  state_ff      <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // shared divider for the fractional error step
   aalr_divider #(
      .DIVIDEND_BITS (COORD_BITS),
      .QUOT_BITS     (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .numer    (div_num_ff),
      .denom    (div_den_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = color_ff;
   assign rsp_chan.weight      = rsp_w_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;
   assign rsp_chan.line_done   = rsp_done_ff;

   // checks
   `AALR_ASSERT_NOW(a_ready_no_output, req_chan.ready, !rsp_valid_ff && !pend_valid_ff,
      "item accepted while a pixel is still waiting")
   `AALR_ASSERT_NOW(a_pend_behind_out, pend_valid_ff, rsp_valid_ff,
      "second pixel of a pair held without a first")
   `AALR_ASSERT_NOW(a_div_general, state_ff == S_DIV,
      kind_ff == KIND_XMAJOR || kind_ff == KIND_YMAJOR,
      "division running for a line that needs none")
   `AALR_ASSERT_NOW(a_idle_no_steps, !line_busy_ff, steps_ff == '0,
      "steps left on a finished line")
   `AALR_ASSERT_NEXT(a_done_leaves_div, state_ff == S_DIV && div_done, state_ff == S_OUT,
      "divider result not taken")

endmodule

>>> tb/sv/aalr_pixel_checker.sv
`timescale 1ns / 1ps

// watches both channels of the rasterizer, predicts the pixels of every
// accepted item and compares each accepted pixel with the oldest prediction
module aalr_pixel_checker #(
   parameter int COORD_BITS    = 12,
   parameter int FRACTION_BITS = 16,
   parameter int WEIGHT_BITS   = 8
) (
   input  logic clock,
   input  logic reset,
   aalr_req_if  req_mon,
   aalr_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pixels_pending
);
   import aalr_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic [COLOR_BITS-1:0]  color;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   last;
      logic                   done;
   } pixel_type;

   // line state of the predictor
   logic [COORD_BITS-1:0]    pos_x;
   logic [COORD_BITS-1:0]    pos_y;
   logic [COORD_BITS-1:0]    end_col;
   logic [COORD_BITS-1:0]    end_row;
   logic                     heading_left;
   logic [COORD_BITS:0]      steps_to_go;
   logic [FRACTION_BITS-1:0] frac_acc;
   logic [FRACTION_BITS-1:0] frac_step;
   line_kind_type            shape;
   logic [COLOR_BITS-1:0]    color_now;
   logic                     drawing;

   pixel_type pixel_queue[$];

   // one column along the line's horizontal direction, wrapping
   function automatic logic [COORD_BITS-1:0] next_col(input logic [COORD_BITS-1:0] col);
      return heading_left ? col - 1'b1 : col + 1'b1;
   endfunction

   task automatic queue_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [WEIGHT_BITS-1:0] w, input logic last,
                              input logic done);
      pixel_type p;
      p.x      = x;
      p.y      = y;
      p.color  = color_now;
      p.weight = w;
      p.last   = last;
      p.done   = done;
      pixel_queue.push_back(p);
   endtask

   // pixels caused by one accepted item
   task automatic predict_item(input command_type cmd,
                               input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                               input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                               input logic [COLOR_BITS-1:0] ci);
      logic [COORD_BITS-1:0]               ax, ay, bx, by, dx, dy;
      logic [COORD_BITS+FRACTION_BITS-1:0] num;
      logic [FRACTION_BITS:0]              sum;
      logic [WEIGHT_BITS-1:0]              w;
      if (cmd == CMD_LOAD) begin
         // order endpoints so rows run upward
         if (sy > ey) begin
            ax = ex; ay = ey; bx = sx; by = sy;
         end else begin
            ax = sx; ay = sy; bx = ex; by = ey;
         end
         heading_left = bx < ax;
         dx = heading_left ? ax - bx : bx - ax;
         dy = by - ay;
         color_now = ci;
         pos_x = ax;
         pos_y = ay;
         end_col = bx;
         end_row = by;
         frac_acc = '0;
         frac_step = '0;
         if (dy == 0) begin
            shape = KIND_HORIZ;
            steps_to_go = {1'b0, dx};
         end else if (dx == 0) begin
            shape = KIND_VERT;
            steps_to_go = {1'b0, dy};
         end else if (dx == dy) begin
            shape = KIND_DIAG;
            steps_to_go = {1'b0, dy};
         end else if (dx > dy) begin
            shape = KIND_XMAJOR;
            steps_to_go = {1'b0, dx};
            num = {dy, {FRACTION_BITS{1'b0}}};
            frac_step = FRACTION_BITS'(num / dx);
         end else begin
            shape = KIND_YMAJOR;
            steps_to_go = {1'b0, dy};
            num = {dx, {FRACTION_BITS{1'b0}}};
            frac_step = FRACTION_BITS'(num / dy);
         end
         drawing = steps_to_go != 0;
         queue_pixel(ax, ay, '0, 1'b1, !drawing);
      end else if (drawing) begin
         if (steps_to_go <= 1) begin
            // endpoint is exact and closes the line
            steps_to_go = '0;
            drawing = 1'b0;
            pos_x = end_col;
            pos_y = end_row;
            queue_pixel(end_col, end_row, '0, 1'b1, 1'b1);
         end else begin
            steps_to_go = steps_to_go - 1'b1;
            case (shape)
               KIND_XMAJOR, KIND_YMAJOR: begin
                  sum = {1'b0, frac_acc} + {1'b0, frac_step};
                  frac_acc = sum[FRACTION_BITS-1:0];
                  w = frac_acc[FRACTION_BITS-1 -: WEIGHT_BITS];
                  if (shape == KIND_XMAJOR) begin
                     if (sum[FRACTION_BITS]) pos_y = pos_y + 1'b1;
                     pos_x = next_col(pos_x);
                     queue_pixel(pos_x, pos_y, w, 1'b0, 1'b0);
                     queue_pixel(pos_x, pos_y + 1'b1, ~w, 1'b1, 1'b0);
                  end else begin
                     if (sum[FRACTION_BITS]) pos_x = next_col(pos_x);
                     pos_y = pos_y + 1'b1;
                     queue_pixel(pos_x, pos_y, w, 1'b0, 1'b0);
                     queue_pixel(next_col(pos_x), pos_y, ~w, 1'b1, 1'b0);
                  end
               end
               KIND_HORIZ: begin
                  pos_x = next_col(pos_x);
                  queue_pixel(pos_x, pos_y, '0, 1'b1, 1'b0);
               end
               KIND_VERT: begin
                  pos_y = pos_y + 1'b1;
                  queue_pixel(pos_x, pos_y, '0, 1'b1, 1'b0);
               end
               default: begin
                  pos_x = next_col(pos_x);
                  pos_y = pos_y + 1'b1;
                  queue_pixel(pos_x, pos_y, '0, 1'b1, 1'b0);
               end
            endcase
         end
      end
   endtask

   task automatic compare_field(input string field, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: pixel %s mismatch, expected %0d, actual %0d",
                  $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         pos_x = '0;
         pos_y = '0;
         end_col = '0;
         end_row = '0;
         heading_left = 1'b0;
         steps_to_go = '0;
         frac_acc = '0;
         frac_step = '0;
         shape = KIND_HORIZ;
         color_now = '0;
         drawing = 1'b0;
         pixel_queue.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_item(req_mon.command, req_mon.start_x, req_mon.start_y,
                         req_mon.end_x, req_mon.end_y, req_mon.color_index);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: pixel mismatch, expected none, actual x %0d y %0d",
                        $time, rsp_mon.pixel_x, rsp_mon.pixel_y);
               mismatch_count++;
            end else begin
               want = pixel_queue.pop_front();
               compare_field("x", int'(want.x), int'(rsp_mon.pixel_x));
               compare_field("y", int'(want.y), int'(rsp_mon.pixel_y));
               compare_field("color", int'(want.color), int'(rsp_mon.pixel_color));
               compare_field("weight", int'(want.weight), int'(rsp_mon.weight));
               compare_field("last_of_run", int'(want.last), int'(rsp_mon.last_of_run));
               compare_field("line_done", int'(want.done), int'(rsp_mon.line_done));
            end
         end
      end
      pixels_pending = pixel_queue.size();
   end

endmodule

>>> tb/sv/antialiased_line_rasterizer_test.sv
`timescale 1ns / 1ps

// stimulus and verdict for the antialiased line rasterizer
module antialiased_line_rasterizer_test;
   import aalr_pkg::*;

   localparam int COORD_BITS    = 12;
   localparam int FRACTION_BITS = 16;
   localparam int WEIGHT_BITS   = 8;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int ITEM_TARGET   = 1300;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic pixel_ready = 1'b0;
   int   stall_left  = 0;
   int   cycle_count = 0;
   int   items_counted = 0;
   int   mismatch_count;
   int   pixels_pending;
   logic calm;

   aalr_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   aalr_rsp_if #(.COORD_BITS(COORD_BITS), .WEIGHT_BITS(WEIGHT_BITS)) rsp_chan ();

   antialiased_line_rasterizer #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   aalr_pixel_checker #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // runs without idling while bits 8 and 7 of the cycle count are both set
   always @(posedge clock) cycle_count <= cycle_count + 1;
   assign calm = cycle_count[8:7] == 2'b11;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // pixel back-pressure
   assign rsp_chan.ready = pixel_ready;
   always @(posedge clock) begin
      int hold;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         pixel_ready <= 1'b0;
      end else begin
         hold = pick_gap();
         stall_left <= hold;
         pixel_ready <= hold == 0;
      end
   end

   task automatic send_item(input command_type cmd,
                            input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                            input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                            input logic [COLOR_BITS-1:0] ci);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.start_x     <= sx;
      req_chan.start_y     <= sy;
      req_chan.end_x       <= ex;
      req_chan.end_y       <= ey;
      req_chan.color_index <= ci;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                            input int ci);
      send_item(CMD_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
                COORD_BITS'(ey), COLOR_BITS'(ci));
      items_counted++;
   endtask

   // step with junk in the unused fields
   task automatic send_step(input bit on_line);
      send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
      if (on_line) items_counted++;
   endtask

   task automatic run_directed();
      // step on an idle block is dropped
      send_step(1'b0);
      // single point line at the far corner
      send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 15);
      send_step(1'b0);
      // horizontal, right to left along the top row
      send_load(3, COORD_MAX, 0, COORD_MAX, 0);
      repeat (3) send_step(1'b1);
      // vertical given top-down, so the endpoints swap
      send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 2, 5);
      repeat (2) send_step(1'b1);
      // diagonal from the origin
      send_load(0, 0, 2, 2, 10);
      repeat (2) send_step(1'b1);
      // x-major leftward, abandoned by a new load
      send_load(10, 20, 0, 23, 9);
      repeat (3) send_step(1'b1);
      // y-major leftward from the right edge, walked to its endpoint
      send_load(COORD_MAX, 0, COORD_MAX - 3, 7, 6);
      repeat (7) send_step(1'b1);
      send_step(1'b0);
   endtask

   // endpoint a short random distance from base, kept on the grid
   function automatic int offset(input int base, input int span);
      int v;
      v = $urandom_range(0, 1) ? base + span : base - span;
      if (v < 0 || v > COORD_MAX) v = 2 * base - v;
      return v;
   endfunction

   // mostly short lines walked to the end; some abandoned, overrun or long
   task automatic run_random();
      int sx, sy, ex, ey, span_x, span_y, length, walk, roll;
      bit far;
      while (items_counted < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         sx = $urandom_range(0, COORD_MAX);
         sy = $urandom_range(0, COORD_MAX);
         far = roll < 6;
         if (far) begin
            ex = $urandom_range(0, COORD_MAX);
            ey = $urandom_range(0, COORD_MAX);
         end else begin
            span_x = $urandom_range(0, 24);
            span_y = $urandom_range(0, 24);
            if (roll < 20) span_y = 0;
            else if (roll < 30) span_x = 0;
            else if (roll < 40) span_y = span_x;
            else if (roll < 43) begin
               span_x = 0;
               span_y = 0;
            end
            ex = offset(sx, span_x);
            ey = offset(sy, span_y);
         end
         span_x = ex > sx ? ex - sx : sx - ex;
         span_y = ey > sy ? ey - sy : sy - ey;
         length = span_x > span_y ? span_x : span_y;
         roll = $urandom_range(0, 99);
         if (far) walk = $urandom_range(0, 40);
         else if (roll < 12) walk = $urandom_range(0, length);
         else if (roll < 20) walk = length + $urandom_range(1, 2);
         else walk = length;
         send_load(sx, sy, ex, ey, $urandom_range(0, 15));
         for (int i = 0; i < walk; i++) send_step(i < length);
      end
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_LOAD;
      req_chan.start_x     = '0;
      req_chan.start_y     = '0;
      req_chan.end_x       = '0;
      req_chan.end_y       = '0;
      req_chan.color_index = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_chan.valid <= 1'b0;
      // drain, then allow the block to settle
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pixels_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule
